FILE: rtl/gzip_member_header_parser_unit_defines.svh
// Assertion macros for the checker file.
`ifndef GZIP_MEMBER_HEADER_PARSER_UNIT_DEFINES_SVH
`define GZIP_MEMBER_HEADER_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define GMHP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GMHP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gmhp_pkg.sv
`default_nettype none

package gmhp_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned HLEN_W      = 32;
  localparam int unsigned OUT_PAYLD_W = STATUS_W + HLEN_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_PAYLD_W + 7) / 8) * 8;
  localparam int unsigned SKIP_W      = 16;
  localparam int unsigned FLAGS_W     = 5;

  localparam logic [7:0] MAGIC_ID1    = 8'h1F;
  localparam logic [7:0] MAGIC_ID2    = 8'h8B;
  localparam logic [7:0] METHOD_DEFL  = 8'h08;
  localparam logic [7:0] FLG_RESERVED = 8'hE0;
  localparam logic [4:0] FLG_HCRC     = 5'h02;
  localparam logic [4:0] FLG_EXTRA    = 5'h04;
  localparam logic [4:0] FLG_NAME     = 5'h08;
  localparam logic [4:0] FLG_COMMENT  = 5'h10;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_TRUNC_HDR   = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_METHOD  = 3'd3,
    ST_RESERVED    = 3'd4,
    ST_TRUNC_EXTRA = 3'd5,
    ST_UNTERM_STR  = 3'd6,
    ST_TRUNC_HCRC  = 3'd7
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/gzip_member_header_parser_unit.sv
// Result: out_* is registered and valid in the cycle after the input transaction that ends the header.
// Throughput: one byte per cycle; the whole per-byte update is combinational logic feeding
// the parser state and the result register, and in_tready stays high while the result
// register is empty or being taken.
// Reset: rst_n is synchronous, active low; it re-arms the parser and empties the result register.
`default_nettype none

module gzip_member_header_parser_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  input  wire logic [gmhp_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] byte_value
  input  wire logic                               in_tlast,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  output      logic [gmhp_pkg::OUT_TDATA_W-1:0]   out_tdata   // [2:0] status, [34:3] header_length
);

  typedef enum logic [3:0] {
    PH_FIXED   = 4'd0,
    PH_XLEN0   = 4'd1,
    PH_XLEN1   = 4'd2,
    PH_XDATA   = 4'd3,
    PH_NAME    = 4'd4,
    PH_COMMENT = 4'd5,
    PH_HCRC0   = 4'd6,
    PH_HCRC1   = 4'd7,
    PH_DONE    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    STG_EXTRA   = 2'd0,
    STG_NAME    = 2'd1,
    STG_COMMENT = 2'd2,
    STG_HCRC    = 2'd3
  } stage_t;

  function automatic phase_t pick(input stage_t stg, input logic [gmhp_pkg::FLAGS_W-1:0] flg);
    phase_t ph;
    ph = PH_DONE;
    priority if (stg <= STG_EXTRA && (flg & gmhp_pkg::FLG_EXTRA) != '0) ph = PH_XLEN0;
    else if (stg <= STG_NAME && (flg & gmhp_pkg::FLG_NAME) != '0) ph = PH_NAME;
    else if (stg <= STG_COMMENT && (flg & gmhp_pkg::FLG_COMMENT) != '0) ph = PH_COMMENT;
    else if ((flg & gmhp_pkg::FLG_HCRC) != '0) ph = PH_HCRC0;
    else ph = PH_DONE;
    return ph;
  endfunction

  function automatic gmhp_pkg::status_t trunc_status(input phase_t ph);
    gmhp_pkg::status_t s;
    unique case (ph)
      PH_FIXED:                    s = gmhp_pkg::ST_TRUNC_HDR;
      PH_XLEN0, PH_XLEN1, PH_XDATA: s = gmhp_pkg::ST_TRUNC_EXTRA;
      PH_NAME, PH_COMMENT:         s = gmhp_pkg::ST_UNTERM_STR;
      default:                     s = gmhp_pkg::ST_TRUNC_HCRC;
    endcase
    return s;
  endfunction

  phase_t                            phase_r, phase_nxt, next_ph;
  logic [3:0]                        fixed_idx_r, fixed_idx_nxt;
  gmhp_pkg::status_t                 held_err_r, held_err_nxt, err, held, st;
  logic [gmhp_pkg::FLAGS_W-1:0]      flags_r, flags_nxt;
  logic [gmhp_pkg::SKIP_W-1:0]       skip_r, skip_nxt;
  logic [gmhp_pkg::HLEN_W-1:0]       seen_r, seen_nxt, seen_inc, len;
  logic                              finished_r, finished_nxt;
  logic                              move, emit, in_acc;
  logic [7:0]                        b;
  logic                              out_valid_r;
  gmhp_pkg::status_t                 status_r;
  logic [gmhp_pkg::HLEN_W-1:0]       hlen_r;

  assign in_tready = ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;
  assign b         = in_tdata[7:0];

  always_comb begin
    phase_nxt     = phase_r;
    fixed_idx_nxt = fixed_idx_r;
    held_err_nxt  = held_err_r;
    flags_nxt     = flags_r;
    skip_nxt      = skip_r;
    seen_nxt      = seen_r;
    finished_nxt  = finished_r;
    next_ph       = PH_FIXED;
    move          = 1'b0;
    emit          = 1'b0;
    st            = gmhp_pkg::ST_OK;
    len           = '0;
    err           = gmhp_pkg::ST_OK;
    held          = held_err_r;
    seen_inc      = (seen_r == '1) ? seen_r : seen_r + 32'd1;
    if (finished_r) begin
      if (in_tlast) begin
        phase_nxt     = PH_FIXED;
        fixed_idx_nxt = '0;
        held_err_nxt  = gmhp_pkg::ST_OK;
        flags_nxt     = '0;
        skip_nxt      = '0;
        seen_nxt      = '0;
        finished_nxt  = 1'b0;
      end
    end else begin
      seen_nxt = seen_inc;
      unique case (phase_r)
        PH_FIXED: begin
          if (fixed_idx_r == 4'd0 && b != gmhp_pkg::MAGIC_ID1) err = gmhp_pkg::ST_BAD_MAGIC;
          if (fixed_idx_r == 4'd1 && b != gmhp_pkg::MAGIC_ID2) err = gmhp_pkg::ST_BAD_MAGIC;
          if (fixed_idx_r == 4'd2 && b != gmhp_pkg::METHOD_DEFL) err = gmhp_pkg::ST_BAD_METHOD;
          if (fixed_idx_r == 4'd3) begin
            if ((b & gmhp_pkg::FLG_RESERVED) != '0) err = gmhp_pkg::ST_RESERVED;
            flags_nxt = b[gmhp_pkg::FLAGS_W-1:0];
          end
          held = (held_err_r == gmhp_pkg::ST_OK) ? err : held_err_r;
          held_err_nxt = held;
          if (fixed_idx_r >= 4'd9) begin
            if (held != gmhp_pkg::ST_OK) begin
              emit = 1'b1;
              st   = held;
            end else begin
              move    = 1'b1;
              next_ph = pick(STG_EXTRA, flags_nxt);
            end
          end else begin
            fixed_idx_nxt = fixed_idx_r + 4'd1;
          end
        end
        PH_XLEN0: begin
          skip_nxt = {8'd0, b};
          move     = 1'b1;
          next_ph  = PH_XLEN1;
        end
        PH_XLEN1: begin
          skip_nxt = {b, skip_r[7:0]};
          move     = 1'b1;
          next_ph  = (skip_nxt == '0) ? pick(STG_NAME, flags_r) : PH_XDATA;
        end
        PH_XDATA: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_nxt == '0) begin
            move    = 1'b1;
            next_ph = pick(STG_NAME, flags_r);
          end
        end
        PH_NAME: begin
          if (b == 8'd0) begin
            move    = 1'b1;
            next_ph = pick(STG_COMMENT, flags_r);
          end
        end
        PH_COMMENT: begin
          if (b == 8'd0) begin
            move    = 1'b1;
            next_ph = pick(STG_HCRC, flags_r);
          end
        end
        PH_HCRC0: begin
          move    = 1'b1;
          next_ph = PH_HCRC1;
        end
        default: begin
          move    = 1'b1;
          next_ph = PH_DONE;
        end
      endcase
      if (!emit) begin
        if (move && next_ph == PH_DONE) begin
          emit = 1'b1;
          st   = gmhp_pkg::ST_OK;
          len  = seen_inc;
        end else begin
          if (move) phase_nxt = next_ph;
          if (in_tlast) begin
            emit = 1'b1;
            st   = trunc_status(phase_nxt);
          end
        end
      end
      if (emit) begin
        if (in_tlast) begin
          phase_nxt     = PH_FIXED;
          fixed_idx_nxt = '0;
          held_err_nxt  = gmhp_pkg::ST_OK;
          flags_nxt     = '0;
          skip_nxt      = '0;
          seen_nxt      = '0;
          finished_nxt  = 1'b0;
        end else begin
          finished_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIXED;
      fixed_idx_r <= '0;
      held_err_r  <= gmhp_pkg::ST_OK;
      flags_r     <= '0;
      skip_r      <= '0;
      seen_r      <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        fixed_idx_r <= fixed_idx_nxt;
        held_err_r  <= held_err_nxt;
        flags_r     <= flags_nxt;
        skip_r      <= skip_nxt;
        seen_r      <= seen_nxt;
        finished_r  <= finished_nxt;
      end
      if (in_acc && emit) begin
        out_valid_r <= 1'b1;
        status_r    <= st;
        hlen_r      <= len;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(gmhp_pkg::OUT_TDATA_W - gmhp_pkg::OUT_PAYLD_W){1'b0}}, hlen_r, status_r};

endmodule

`default_nettype wire

FILE: rtl/gmhp_checker.sv
`default_nettype none
`include "gzip_member_header_parser_unit_defines.svh"

module gmhp_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [gmhp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic                             in_tlast,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [gmhp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                               in_acc;
  logic [gmhp_pkg::STATUS_W-1:0]      status;
  logic [gmhp_pkg::HLEN_W-1:0]        hlen;

  assign in_acc = in_tvalid & in_tready & (in_tlast | ~in_tlast) & (in_tdata == in_tdata);
  assign status = out_tdata[gmhp_pkg::STATUS_W-1:0];
  assign hlen   = out_tdata[gmhp_pkg::OUT_PAYLD_W-1:gmhp_pkg::STATUS_W];

  `GMHP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `GMHP_ASSERT_NEXT(a_out_cause, clk, rst_n, !out_tvalid && !in_acc, !out_tvalid, "result without input transaction")
  `GMHP_ASSERT_NOW(a_err_len, clk, rst_n, out_tvalid && status != gmhp_pkg::ST_OK, hlen == '0, "length on error status")
  `GMHP_ASSERT_NOW(a_ok_len, clk, rst_n, out_tvalid && status == gmhp_pkg::ST_OK, hlen >= 32'd10, "ok header shorter than fixed part")
  `GMHP_ASSERT_NOW(a_pad, clk, rst_n, out_tvalid, out_tdata[gmhp_pkg::OUT_TDATA_W-1:gmhp_pkg::OUT_PAYLD_W] == '0, "nonzero padding")

endmodule

bind gzip_member_header_parser_unit gmhp_checker u_gmhp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
